@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers, sampled on clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition never holds.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

@@ rtl/tli_pkg.sv @@
`timescale 1ns / 1ps
package tli_pkg;

	localparam int POINTS_DEFAULT = 1024;
	localparam int VALUE_WIDTH_DEFAULT = 32;

	localparam int DATA_W = 32;
	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd2;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_POINT_COUNT = 1'b0;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_QUERY = 1'b1
	} req_type_t;

endpackage

@@ rtl/tli_if.sv @@
`timescale 1ns / 1ps
interface tli_req_if import tli_pkg::*; ();
	logic valid;
	logic ready;
	req_type_t req_type;
	logic [INDEX_W-1:0] point_index;
	logic signed [DATA_W-1:0] point_x;
	logic signed [DATA_W-1:0] point_y;
	logic signed [DATA_W-1:0] query_x;

	modport source (
		output valid, req_type, point_index, point_x, point_y, query_x,
		input ready
	);
	modport sink (
		input valid, req_type, point_index, point_x, point_y, query_x,
		output ready
	);
endinterface

interface tli_res_if import tli_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DATA_W-1:0] result_y;
	logic clamped_low;
	logic clamped_high;

	modport source (
		output valid, result_y, clamped_low, clamped_high,
		input ready
	);
	modport sink (
		input valid, result_y, clamped_low, clamped_high,
		output ready
	);
endinterface

@@ rtl/table_linear_interpolator_core.sv @@
// Table linear interpolator.
// The req channel carries load and query items. A load writes one breakpoint
// (x, y) into the table and gives no result. A query
// gives one item on the res channel: the first y with clamped_low when the
// query is at or below the first x, the last y with clamped_high when it is
// at or above the last x in use, else the linear interpolation between the
// bracketing breakpoints, saturated to the value range.
// A clamped query ends at a bound check. An interior query searches the table
// with one table read per search step, fetches the bracketing pair,
// multiplies, checks for overflow, then does one restoring divide step per
// quotient bit. req.ready is high only while no query is in work.
// point_count is written over the APB port at byte address 0; the user must
// write it only while idle, as the block itself does not enforce it.
// Reset clears the sequencer and output valid and sets point_count to 2; the
// table is not cleared, and each entry must be loaded before it is read.
// The result waits in an output register while res.ready is low; loads and a
// new query are still taken, and that query holds its result until the
// output register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module table_linear_interpolator_core import tli_pkg::*; #(
	parameter int MAX_POINTS = POINTS_DEFAULT,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	tli_req_if.sink req,
	tli_res_if.source res,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic pready
);

	localparam int EW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNTW = $clog2(EW + 1);
	localparam logic signed [EW-1:0] VMAX = {1'b0, {(EW-1){1'b1}}};
	localparam logic signed [EW-1:0] VMIN = {1'b1, {(EW-1){1'b0}}};

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_CHK_LO  = 11'b00000000010,
		S_CHK_HI  = 11'b00000000100,
		S_SRCH    = 11'b00000001000,
		S_FETCH_L = 11'b00000010000,
		S_FETCH_H = 11'b00000100000,
		S_MUL     = 11'b00001000000,
		S_OVF     = 11'b00010000000,
		S_DIV     = 11'b00100000000,
		S_FIN     = 11'b01000000000,
		S_DONE    = 11'b10000000000
	} state_t;

	state_t state_q, state_n;

	logic [COUNT_W-1:0] point_count_q;
	logic signed [EW-1:0] mem_x [MAX_POINTS];
	logic signed [EW-1:0] mem_y [MAX_POINTS];
	logic signed [EW-1:0] rd_x_q, rd_y_q;
	logic [AW-1:0] rd_addr;

	logic signed [EW-1:0] q_q, xl_q, yl_q, res_q;
	logic [AW-1:0] lo_q, up_q, mid_q, last;
	logic [AW-1:0] lo_n, up_n, mid_n;
	logic span_gt1;
	logic [AW:0] mid_sum;
	logic [31:0] cnt32;

	logic [EW-1:0] dq_mag_q, dy_mag_q, dx_mag_q;
	logic dq_neg_q, neg_q, dx_zero_q;
	logic [2*EW-1:0] prod_q;
	logic [EW-1:0] rem_q, quo_q;
	logic [CNTW-1:0] cnt_q;
	logic clo_q, chi_q;

	logic signed [EW:0] dq, dy, dx;
	logic [EW:0] dq_abs, dy_abs, dx_abs;
	logic [EW:0] div_trial, div_diff;
	logic div_ge;
	logic signed [EW+1:0] sum;
	logic signed [EW-1:0] sat;

	logic wr_en, out_free;
	logic out_valid_q, out_clo_q, out_chi_q;
	logic signed [DATA_W-1:0] out_y_q;

	logic q_le_x, q_ge_x, q_gt_x;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= COUNT_RESET;
		end else if (psel && penable && pwrite && paddr[APB_ADDR_W-1] == REG_POINT_COUNT) begin
			point_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		case (paddr[APB_ADDR_W-1])
			REG_POINT_COUNT: prdata = APB_DATA_W'(point_count_q);
			default:         prdata = '0;
		endcase
	end

	always_comb begin
		cnt32 = 32'(point_count_q);
		if (cnt32 < 32'd2) begin
			last = AW'(1);
		end else if (cnt32 > 32'(MAX_POINTS)) begin
			last = AW'(MAX_POINTS - 1);
		end else begin
			last = AW'(cnt32 - 32'd1);
		end
	end

	// table
	assign req.ready = (state_q == S_IDLE);
	assign wr_en = req.valid && req.ready && req.req_type == REQ_LOAD
		&& 32'(req.point_index) < 32'(MAX_POINTS);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[AW'(32'(req.point_index))] <= req.point_x[EW-1:0];
			mem_y[AW'(32'(req.point_index))] <= req.point_y[EW-1:0];
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	// search control
	assign q_le_x = q_q <= rd_x_q;
	assign q_ge_x = q_q >= rd_x_q;
	assign q_gt_x = q_q > rd_x_q;

	always_comb begin
		if (state_q == S_SRCH) begin
			lo_n = q_gt_x ? mid_q : lo_q;
			up_n = q_gt_x ? up_q : mid_q;
		end else begin
			lo_n = '0;
			up_n = last;
		end
		mid_sum = (AW+1)'(lo_n) + (AW+1)'(up_n);
		mid_n = mid_sum[AW:1];
		span_gt1 = (up_n - lo_n) > AW'(1);
	end

	// arithmetic
	assign dq = (EW+1)'(q_q) - (EW+1)'(rd_x_q);
	assign dy = (EW+1)'(rd_y_q) - (EW+1)'(yl_q);
	assign dx = (EW+1)'(rd_x_q) - (EW+1)'(xl_q);
	assign dq_abs = dq[EW] ? -dq : dq;
	assign dy_abs = dy[EW] ? -dy : dy;
	assign dx_abs = dx[EW] ? -dx : dx;

	assign div_trial = {rem_q, quo_q[EW-1]};
	assign div_diff = div_trial - {1'b0, dx_mag_q};
	assign div_ge = div_trial >= {1'b0, dx_mag_q};

	always_comb begin
		if (neg_q) begin
			sum = (EW+2)'(yl_q) - $signed({2'b00, quo_q});
		end else begin
			sum = (EW+2)'(yl_q) + $signed({2'b00, quo_q});
		end
		if (sum > (EW+2)'(VMAX)) begin
			sat = VMAX;
		end else if (sum < (EW+2)'(VMIN)) begin
			sat = VMIN;
		end else begin
			sat = sum[EW-1:0];
		end
	end

	assign out_free = !out_valid_q || res.ready;

	// sequencer
	always_comb begin
		state_n = state_q;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (req.valid && req.req_type == REQ_QUERY) begin
					state_n = S_CHK_LO;
				end
			end
			S_CHK_LO: begin
				rd_addr = last;
				state_n = q_le_x ? S_DONE : S_CHK_HI;
			end
			S_CHK_HI, S_SRCH: begin
				rd_addr = span_gt1 ? mid_n : lo_n;
				if (state_q == S_CHK_HI && q_ge_x) begin
					state_n = S_DONE;
				end else begin
					state_n = span_gt1 ? S_SRCH : S_FETCH_L;
				end
			end
			S_FETCH_L: begin
				rd_addr = lo_q + AW'(1);
				state_n = S_FETCH_H;
			end
			S_FETCH_H: state_n = S_MUL;
			S_MUL:     state_n = S_OVF;
			S_OVF: begin
				if (dx_zero_q || prod_q[2*EW-1:EW] >= dx_mag_q) begin
					state_n = S_DONE;
				end else begin
					state_n = S_DIV;
				end
			end
			S_DIV: begin
				if (cnt_q == CNTW'(1)) begin
					state_n = S_FIN;
				end
			end
			S_FIN: state_n = S_DONE;
			S_DONE: begin
				if (out_free) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				q_q <= req.query_x[EW-1:0];
			end
			S_CHK_LO: begin
				res_q <= rd_y_q;
				clo_q <= 1'b1;
				chi_q <= 1'b0;
			end
			S_CHK_HI, S_SRCH: begin
				if (state_q == S_CHK_HI) begin
					res_q <= rd_y_q;
					clo_q <= 1'b0;
					chi_q <= 1'b1;
				end
				lo_q <= lo_n;
				up_q <= up_n;
				mid_q <= mid_n;
			end
			S_FETCH_L: begin
				xl_q <= rd_x_q;
				yl_q <= rd_y_q;
				dq_neg_q <= dq[EW];
				dq_mag_q <= dq_abs[EW-1:0];
				clo_q <= 1'b0;
				chi_q <= 1'b0;
			end
			S_FETCH_H: begin
				dy_mag_q <= dy_abs[EW-1:0];
				dx_mag_q <= dx_abs[EW-1:0];
				neg_q <= (dy[EW] != dq_neg_q) != dx[EW];
				dx_zero_q <= (dx == '0);
			end
			S_MUL: begin
				prod_q <= (2*EW)'(dy_mag_q) * (2*EW)'(dq_mag_q);
			end
			S_OVF: begin
				if (dx_zero_q) begin
					res_q <= yl_q;
				end else begin
					res_q <= neg_q ? VMIN : VMAX;
				end
				rem_q <= prod_q[2*EW-1:EW];
				quo_q <= prod_q[EW-1:0];
				cnt_q <= CNTW'(EW);
			end
			S_DIV: begin
				rem_q <= div_ge ? div_diff[EW-1:0] : div_trial[EW-1:0];
				quo_q <= {quo_q[EW-2:0], div_ge};
				cnt_q <= cnt_q - CNTW'(1);
			end
			S_FIN: begin
				res_q <= sat;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_y_q <= DATA_W'(res_q);
			out_clo_q <= clo_q;
			out_chi_q <= chi_q;
		end
	end

	assign res.valid = out_valid_q;
	assign res.result_y = out_y_q;
	assign res.clamped_low = out_clo_q;
	assign res.clamped_high = out_chi_q;

	`ASSERT_ALWAYS(a_srch_span, state_q == S_SRCH |-> (up_q > lo_q) && (up_q - lo_q > AW'(1)),
		"search interval collapsed")
	`ASSERT_ALWAYS(a_fetch_below_last, state_q == S_FETCH_L |-> lo_q < last,
		"interval start at or past last point")
	`ASSERT_ALWAYS(a_rem_below_div, state_q == S_DIV |-> rem_q < dx_mag_q,
		"divide remainder not below divisor")
	`ASSERT_NEVER(a_both_clamps, res.valid && res.clamped_low && res.clamped_high,
		"both clamp flags set")

endmodule

@@ tb/table_linear_interpolator_core_tb.sv @@
`timescale 1ns / 1ps
module table_linear_interpolator_core_tb;
	import tli_pkg::*;

	localparam int MAX_PTS = POINTS_DEFAULT;
	localparam int RANDOM_ITEMS = 1350;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam longint VAL_MAX = 2147483647;
	localparam longint VAL_MIN = -VAL_MAX - 1;
	localparam logic [APB_ADDR_W-1:0] COUNT_ADDR = {REG_POINT_COUNT, 2'b00};

	typedef longint unsigned u64_t;

	typedef struct {
		req_type_t kind;
		logic [INDEX_W-1:0] idx;
		logic signed [DATA_W-1:0] px;
		logic signed [DATA_W-1:0] py;
		logic signed [DATA_W-1:0] qx;
	} req_item_t;

	typedef struct {
		logic signed [DATA_W-1:0] result_y;
		logic clamped_low;
		logic clamped_high;
	} interp_res_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	tli_req_if req_if ();
	tli_res_if res_if ();

	table_linear_interpolator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.res(res_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	logic signed [DATA_W-1:0] tbl_x [MAX_PTS];
	logic signed [DATA_W-1:0] tbl_y [MAX_PTS];
	bit tbl_loaded [MAX_PTS];
	logic [COUNT_W-1:0] count_reg;

	interp_res_t pending_results [$];

	int req_gap_max;
	int res_stall_max;
	int res_wait_left;
	int hold_off_left;
	int mismatch_count;
	int items_sent;
	int load_count;
	int query_count;
	int interior_count;
	int low_count;
	int high_count;
	int cfg_writes;
	int cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("table_linear_interpolator_core_tb: done, errors");
		$finish;
	end

	function automatic int unsigned points_active();
		if (count_reg < 2) return 2;
		if (count_reg > MAX_PTS) return MAX_PTS;
		return count_reg;
	endfunction

	function automatic u64_t mag(input longint v);
		return (v < 0) ? u64_t'(-v) : u64_t'(v);
	endfunction

	function automatic bit interp_predict(input logic signed [DATA_W-1:0] q,
		output interp_res_t r);
		int unsigned last;
		int unsigned lo;
		int unsigned up;
		int unsigned mid;
		longint xl, xh, yl, yh, dy, dq, dx, val;
		u64_t quot;
		bit neg;
		last = points_active() - 1;
		r.result_y = '0;
		r.clamped_low = 1'b0;
		r.clamped_high = 1'b0;
		if (!tbl_loaded[0]) return 1'b0;
		if (q <= tbl_x[0]) begin
			r.result_y = tbl_y[0];
			r.clamped_low = 1'b1;
			return 1'b1;
		end
		if (!tbl_loaded[last]) return 1'b0;
		if (q >= tbl_x[last]) begin
			r.result_y = tbl_y[last];
			r.clamped_high = 1'b1;
			return 1'b1;
		end
		lo = 0;
		up = last;
		while (up - lo > 1) begin
			mid = (lo + up) >> 1;
			if (!tbl_loaded[mid]) return 1'b0;
			if (q > tbl_x[mid]) lo = mid;
			else up = mid;
		end
		xl = tbl_x[lo];
		xh = tbl_x[lo + 1];
		yl = tbl_y[lo];
		yh = tbl_y[lo + 1];
		dy = yh - yl;
		dq = longint'(q) - xl;
		dx = xh - xl;
		if (dx == 0) begin
			val = yl;
		end else begin
			quot = (mag(dy) * mag(dq)) / mag(dx);
			if (quot > (u64_t'(1) << 34)) quot = u64_t'(1) << 34;
			neg = ((dy < 0) != (dq < 0)) != (dx < 0);
			val = neg ? yl - longint'(quot) : yl + longint'(quot);
		end
		if (val > VAL_MAX) val = VAL_MAX;
		if (val < VAL_MIN) val = VAL_MIN;
		r.result_y = val[DATA_W-1:0];
		return 1'b1;
	endfunction

	function automatic req_item_t make_load(input int unsigned idx, input logic [31:0] x,
		input logic [31:0] y);
		req_item_t it;
		it.kind = REQ_LOAD;
		it.idx = idx[INDEX_W-1:0];
		it.px = x;
		it.py = y;
		it.qx = $urandom();
		return it;
	endfunction

	function automatic req_item_t make_query(input logic [31:0] q);
		req_item_t it;
		it.kind = REQ_QUERY;
		it.idx = $urandom();
		it.px = $urandom();
		it.py = $urandom();
		it.qx = q;
		return it;
	endfunction

	function automatic logic [31:0] pick_query();
		int unsigned last;
		int unsigned k;
		int unsigned sel;
		longint gap;
		last = points_active() - 1;
		sel = $urandom_range(0, 19);
		if (sel < 12) begin
			k = $urandom_range(0, last - 1);
			gap = longint'(tbl_x[k + 1]) - longint'(tbl_x[k]);
			if (gap < 1) return tbl_x[k];
			return 32'(longint'(tbl_x[k]) + longint'($urandom_range(1, 32'(gap))));
		end
		if (sel < 15) return tbl_x[$urandom_range(0, last)];
		if (sel == 15) return tbl_x[0] - $urandom_range(0, 1000);
		if (sel == 16) return tbl_x[last] + $urandom_range(0, 1000);
		return $urandom();
	endfunction

	task automatic send_req(input req_item_t it);
		interp_res_t want;
		int gap;
		if (it.kind == REQ_QUERY && !interp_predict(it.qx, want)) return;
		gap = $urandom_range(0, req_gap_max);
		repeat (gap) begin
			@(negedge clk);
			req_if.valid <= 1'b0;
		end
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.req_type <= it.kind;
		req_if.point_index <= it.idx;
		req_if.point_x <= it.px;
		req_if.point_y <= it.py;
		req_if.query_x <= it.qx;
		do @(posedge clk); while (!req_if.ready);
		items_sent++;
		if (it.kind == REQ_LOAD) begin
			tbl_x[it.idx] = it.px;
			tbl_y[it.idx] = it.py;
			tbl_loaded[it.idx] = 1'b1;
			load_count++;
		end else begin
			pending_results.push_back(want);
			query_count++;
			if (want.clamped_low) low_count++;
			else if (want.clamped_high) high_count++;
			else interior_count++;
		end
	endtask

	task automatic set_point_count(input int unsigned value);
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COUNT_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		count_reg = value[COUNT_W-1:0];
		cfg_writes++;
	endtask

	task automatic load_sorted_table(input int unsigned n);
		longint span;
		longint step_max;
		longint x;
		int unsigned sel;
		span = 64'd4294967295;
		step_max = span / n;
		sel = $urandom_range(0, 2);
		if (sel == 1 && step_max > 1048576) step_max = 1048576;
		if (sel == 2 && step_max > 300) step_max = 300;
		x = -64'sd2147483648 + longint'($urandom_range(0, 32'(span - (n - 1) * step_max)));
		for (int unsigned i = 0; i < n; i++) begin
			send_req(make_load(i, 32'(x), $urandom()));
			x += longint'($urandom_range(1, 32'(step_max)));
		end
	endtask

	task automatic test_reset_count();
		send_req(make_load(0, 32'shffff0000, 32'sh00030000));
		send_req(make_load(1, 32'sh00020000, 32'shfffb0000));
		send_req(make_query(32'shfffe0000));
		send_req(make_query(32'shffff0000));
		send_req(make_query(32'sh00000000));
		send_req(make_query(32'sh00020000));
		send_req(make_query(32'sh7fffffff));
	endtask

	task automatic test_value_extremes();
		set_point_count(3);
		send_req(make_load(0, 32'sh80000000, 32'sh7fffffff));
		send_req(make_load(1, 32'sh00000000, 32'sh80000000));
		send_req(make_load(2, 32'sh7fffffff, 32'sh7fffffff));
		send_req(make_query(32'sh80000000));
		send_req(make_query(32'sh80000001));
		send_req(make_query(32'sh00000000));
		send_req(make_query(32'sh00000001));
		send_req(make_query(32'sh7ffffffe));
		send_req(make_query(32'sh7fffffff));
	endtask

	task automatic test_count_floor();
		set_point_count(0);
		send_req(make_query(32'sh7fffffff));
		send_req(make_query(32'sh00000000));
		send_req(make_query(32'sh80000000));
		set_point_count(1);
		send_req(make_query(32'sh40000000));
	endtask

	task automatic test_both_clamps();
		set_point_count(2);
		send_req(make_load(0, 32'sh00010000, 32'sh00050000));
		send_req(make_load(1, 32'shffff0000, 32'shfff90000));
		send_req(make_query(32'sh00000000));
		send_req(make_query(32'sh7fffffff));
	endtask

	task automatic test_full_table();
		set_point_count(MAX_PTS);
		load_sorted_table(MAX_PTS);
		repeat (40) send_req(make_query(pick_query()));
		set_point_count(2047);
		repeat (20) send_req(make_query(pick_query()));
		set_point_count(MAX_PTS + 1);
		repeat (15) send_req(make_query(pick_query()));
		set_point_count(1000);
		repeat (20) send_req(make_query(pick_query()));
	endtask

	task automatic test_output_stall();
		set_point_count(8);
		load_sorted_table(8);
		req_gap_max = 0;
		hold_off_left = 400;
		repeat (24) send_req(make_query(pick_query()));
		req_gap_max = 8;
	endtask

	task automatic test_random_tables();
		int unsigned n;
		int unsigned sel;
		int base;
		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 19);
			if (sel < 14) n = $urandom_range(2, 16);
			else if (sel < 19) n = $urandom_range(17, 64);
			else n = $urandom_range(65, 256);
			if (n == 2 && $urandom_range(0, 1) == 1) set_point_count($urandom_range(0, 1));
			else set_point_count(n);
			req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			res_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			if ($urandom_range(0, 6) == 0) begin
				for (int unsigned i = 0; i < n; i++)
					send_req(make_load(i, $urandom(), $urandom()));
			end else begin
				load_sorted_table(n);
			end
			repeat ($urandom_range(8, 30)) begin
				sel = $urandom_range(0, 9);
				if (sel == 0)
					send_req(make_load($urandom_range(0, n - 1), $urandom(), $urandom()));
				else if (sel == 1)
					send_req(make_load($urandom_range(0, MAX_PTS - 1), $urandom(),
						$urandom()));
				else
					send_req(make_query(pick_query()));
			end
		end
		req_gap_max = 8;
		res_stall_max = 8;
	endtask

	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				res_if.ready <= 1'b0;
				hold_off_left--;
			end else if (res_wait_left > 0) begin
				res_if.ready <= 1'b0;
				res_wait_left--;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	initial begin : result_check
		interp_res_t want;
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, got result_y %h low %b high %b",
						$time, res_if.result_y, res_if.clamped_low, res_if.clamped_high);
					mismatch_count++;
				end else begin
					want = pending_results.pop_front();
					if (res_if.result_y !== want.result_y) begin
						$display("%0t: result_y mismatch, expected %h, got %h",
							$time, want.result_y, res_if.result_y);
						mismatch_count++;
					end
					if (res_if.clamped_low !== want.clamped_low) begin
						$display("%0t: clamped_low mismatch, expected %b, got %b",
							$time, want.clamped_low, res_if.clamped_low);
						mismatch_count++;
					end
					if (res_if.clamped_high !== want.clamped_high) begin
						$display("%0t: clamped_high mismatch, expected %b, got %b",
							$time, want.clamped_high, res_if.clamped_high);
						mismatch_count++;
					end
				end
				res_wait_left = $urandom_range(0, res_stall_max);
			end
		end
	end

	initial begin
		int guard;
		arst_n = 1'b0;
		req_if.valid <= 1'b0;
		req_if.req_type <= REQ_LOAD;
		req_if.point_index <= '0;
		req_if.point_x <= '0;
		req_if.point_y <= '0;
		req_if.query_x <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		count_reg = COUNT_RESET;
		req_gap_max = 8;
		res_stall_max = 8;
		res_wait_left = 0;
		hold_off_left = 0;
		mismatch_count = 0;
		items_sent = 0;
		load_count = 0;
		query_count = 0;
		interior_count = 0;
		low_count = 0;
		high_count = 0;
		cfg_writes = 0;
		for (int i = 0; i < MAX_PTS; i++) begin
			tbl_x[i] = '0;
			tbl_y[i] = '0;
			tbl_loaded[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_count();
		test_value_extremes();
		test_count_floor();
		test_both_clamps();
		test_full_table();
		test_output_stall();
		test_random_tables();

		@(negedge clk);
		req_if.valid <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			mismatch_count++;
		end
		$display("covered %0d loads and %0d queries: %0d interior, %0d low, %0d high clamps",
			load_count, query_count, interior_count, low_count, high_count);
		$display("%0d point_count writes, %0d cycles, %0d errors",
			cfg_writes, cycles, mismatch_count);
		if (mismatch_count == 0) begin
			$display("table_linear_interpolator_core_tb: done, clean");
		end else begin
			$display("table_linear_interpolator_core_tb: done, errors");
		end
		$finish;
	end

endmodule
